// ===== hw/rtl/si_pkg.sv =====
package si_pkg;

  localparam int OUT_BITS = 32;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    neg_x;
    logic    neg_y;
  } ctl_t;

endpackage

// ===== hw/rtl/si_if.sv =====
interface si_in_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface si_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [si_pkg::OUT_BITS-1:0] cross_x;
  logic signed [si_pkg::OUT_BITS-1:0] cross_y;

  modport source (output valid, status, cross_x, cross_y, input ready);
  modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface

// ===== hw/rtl/si_front.sv =====
module si_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  si_in_if.sink seg_in,
  output logic dn_valid,
  input  logic dn_ready,
  output si_pkg::ctl_t dn_ctl,
  output logic [2*COORD_BITS:0] dn_d,
  output logic [2*COORD_BITS+1:0] dn_rem_x,
  output logic [2*COORD_BITS+1:0] dn_rem_y,
  output logic [COORD_BITS+FRAC_BITS-1:0] dn_l_x,
  output logic [COORD_BITS+FRAC_BITS-1:0] dn_l_y
);
  localparam int C  = COORD_BITS;
  localparam int AB = C + 1;
  localparam int CW = 2*C + 2;
  localparam int DW = 2*C + 2;
  localparam int NW = 3*C + 4;
  localparam int D  = 2*C + 1;
  localparam int RW = D + 1;
  localparam int QB = C + FRAC_BITS;

  logic v [6];
  logic en [7];

  logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [AB-1:0] a1, b1, a2, b2;
  logic signed [AB-1:0] a1_2, b1_2, a2_2, b2_2, a1_3, b1_3, a2_3, b2_3;
  logic signed [CW-1:0] pa1x1, pb1y1, pa2x3, pb2y3;
  logic signed [DW-1:0] pa1b2, pa2b1;
  logic signed [C-1:0] lox2, hix2, loy2, hiy2, lox3, hix3, loy3, hiy3;
  logic signed [C-1:0] lox4, hix4, loy4, hiy4, lox5, hix5, loy5, hiy5;
  logic signed [CW-1:0] c1, c2;
  logic signed [DW-1:0] det3, det4;
  logic signed [NW-1:0] m1, m2, m3, m4;
  logic signed [NW-1:0] nx5, ny5, nx6, ny6;
  logic signed [DW-1:0] d5, d6;
  logic zero5, zero6;
  logic signed [NW-1:0] plx, phx, ply, phy;

  logic signed [C-1:0] lox_c, hix_c, loy_c, hiy_c;
  logic signed [NW-1:0] mag_x, mag_y;
  logic hit;

  always_comb begin
    en[6] = dn_ready;
    for (int k = 5; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign seg_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (en[0]) v[0] <= seg_in.valid;
      for (int k = 1; k < 6; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // box of the overlap of both segment boxes
  always_comb begin
    lox_c = (x1 < x2) ? x1 : x2;
    if (((x3 < x4) ? x3 : x4) > lox_c) lox_c = (x3 < x4) ? x3 : x4;
    hix_c = (x1 > x2) ? x1 : x2;
    if (((x3 > x4) ? x3 : x4) < hix_c) hix_c = (x3 > x4) ? x3 : x4;
    loy_c = (y1 < y2) ? y1 : y2;
    if (((y3 < y4) ? y3 : y4) > loy_c) loy_c = (y3 < y4) ? y3 : y4;
    hiy_c = (y1 > y2) ? y1 : y2;
    if (((y3 > y4) ? y3 : y4) < hiy_c) hiy_c = (y3 > y4) ? y3 : y4;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1 <= seg_in.first_start_x;
      y1 <= seg_in.first_start_y;
      x2 <= seg_in.first_end_x;
      y2 <= seg_in.first_end_y;
      x3 <= seg_in.second_start_x;
      y3 <= seg_in.second_start_y;
      x4 <= seg_in.second_end_x;
      y4 <= seg_in.second_end_y;
      a1 <= AB'(seg_in.first_end_y) - AB'(seg_in.first_start_y);
      b1 <= AB'(seg_in.first_start_x) - AB'(seg_in.first_end_x);
      a2 <= AB'(seg_in.second_end_y) - AB'(seg_in.second_start_y);
      b2 <= AB'(seg_in.second_start_x) - AB'(seg_in.second_end_x);
    end
    if (en[1]) begin
      pa1x1 <= CW'(a1) * CW'(x1);
      pb1y1 <= CW'(b1) * CW'(y1);
      pa2x3 <= CW'(a2) * CW'(x3);
      pb2y3 <= CW'(b2) * CW'(y3);
      pa1b2 <= DW'(a1) * DW'(b2);
      pa2b1 <= DW'(a2) * DW'(b1);
      a1_2 <= a1;
      b1_2 <= b1;
      a2_2 <= a2;
      b2_2 <= b2;
      lox2 <= lox_c;
      hix2 <= hix_c;
      loy2 <= loy_c;
      hiy2 <= hiy_c;
    end
    if (en[2]) begin
      c1 <= pa1x1 + pb1y1;
      c2 <= pa2x3 + pb2y3;
      det3 <= pa1b2 - pa2b1;
      a1_3 <= a1_2;
      b1_3 <= b1_2;
      a2_3 <= a2_2;
      b2_3 <= b2_2;
      lox3 <= lox2;
      hix3 <= hix2;
      loy3 <= loy2;
      hiy3 <= hiy2;
    end
    if (en[3]) begin
      m1 <= NW'(b2_3) * NW'(c1);
      m2 <= NW'(b1_3) * NW'(c2);
      m3 <= NW'(a1_3) * NW'(c2);
      m4 <= NW'(a2_3) * NW'(c1);
      det4 <= det3;
      lox4 <= lox3;
      hix4 <= hix3;
      loy4 <= loy3;
      hiy4 <= hiy3;
    end
    if (en[4]) begin
      // normalise to a positive determinant
      nx5 <= det4[DW-1] ? (m2 - m1) : (m1 - m2);
      ny5 <= det4[DW-1] ? (m4 - m3) : (m3 - m4);
      d5 <= det4[DW-1] ? -det4 : det4;
      zero5 <= (det4 == '0);
      lox5 <= lox4;
      hix5 <= hix4;
      loy5 <= loy4;
      hiy5 <= hiy4;
    end
    if (en[5]) begin
      plx <= NW'(lox5) * NW'(d5);
      phx <= NW'(hix5) * NW'(d5);
      ply <= NW'(loy5) * NW'(d5);
      phy <= NW'(hiy5) * NW'(d5);
      nx6 <= nx5;
      ny6 <= ny5;
      d6 <= d5;
      zero6 <= zero5;
    end
  end

  // exact box test on the rational point, borders included
  always_comb begin
    hit = (nx6 >= plx) && (nx6 <= phx) && (ny6 >= ply) && (ny6 <= phy);
    mag_x = nx6[NW-1] ? -nx6 : nx6;
    mag_y = ny6[NW-1] ? -ny6 : ny6;
    dn_ctl.neg_x = nx6[NW-1];
    dn_ctl.neg_y = ny6[NW-1];
    if (zero6) begin
      dn_ctl.status = si_pkg::ST_PARALLEL;
    end else if (hit) begin
      dn_ctl.status = si_pkg::ST_HIT;
    end else begin
      dn_ctl.status = si_pkg::ST_OUTSIDE;
    end
  end

  assign dn_valid = v[5];
  assign dn_d     = D'(d6);
  assign dn_rem_x = RW'(mag_x >> C);
  assign dn_rem_y = RW'(mag_y >> C);
  assign dn_l_x   = QB'(mag_x[C-1:0]) << FRAC_BITS;
  assign dn_l_y   = QB'(mag_y[C-1:0]) << FRAC_BITS;

endmodule

// ===== hw/rtl/si_div_cell.sv =====
module si_div_cell #(
  parameter int D  = 33,
  parameter int QB = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  si_pkg::ctl_t up_ctl,
  input  logic [D-1:0] up_d,
  input  logic [D:0] up_rem_x,
  input  logic [D:0] up_rem_y,
  input  logic [QB-1:0] up_l_x,
  input  logic [QB-1:0] up_l_y,
  input  logic [QB-1:0] up_q_x,
  input  logic [QB-1:0] up_q_y,
  output logic dn_valid,
  input  logic dn_ready,
  output si_pkg::ctl_t dn_ctl,
  output logic [D-1:0] dn_d,
  output logic [D:0] dn_rem_x,
  output logic [D:0] dn_rem_y,
  output logic [QB-1:0] dn_l_x,
  output logic [QB-1:0] dn_l_y,
  output logic [QB-1:0] dn_q_x,
  output logic [QB-1:0] dn_q_y
);
  logic [D:0] tx, ty;
  logic gx, gy;

  // one restoring step for each coordinate
  always_comb begin
    tx = {up_rem_x[D-1:0], up_l_x[QB-1]};
    ty = {up_rem_y[D-1:0], up_l_y[QB-1]};
    gx = tx >= {1'b0, up_d};
    gy = ty >= {1'b0, up_d};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_ctl   <= up_ctl;
      dn_d     <= up_d;
      dn_rem_x <= gx ? (tx - {1'b0, up_d}) : tx;
      dn_rem_y <= gy ? (ty - {1'b0, up_d}) : ty;
      dn_l_x   <= up_l_x << 1;
      dn_l_y   <= up_l_y << 1;
      dn_q_x   <= {up_q_x[QB-2:0], gx};
      dn_q_y   <= {up_q_y[QB-2:0], gy};
    end
  end

endmodule

// ===== hw/rtl/segment_intersection_top.sv =====
// channel   dir  payload
// seg_in    in   eight endpoint coordinates, two segments
// seg_out   out  status, cross_x, cross_y
//
// one transaction per cycle sustained while seg_out.ready stays high
// front pipeline of six stages, then one quotient bit per cell in the divider chain
// each stage takes data when empty or when the next stage moves, so bubbles close up
// synchronous reset clears all valid bits; payload registers are not reset
module segment_intersection_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  si_in_if.sink   seg_in,
  si_out_if.source seg_out
);
  localparam int D  = 2*COORD_BITS + 1;
  localparam int QB = COORD_BITS + FRAC_BITS;
  localparam int XW = (QB + 1 > si_pkg::OUT_BITS) ? QB + 1 : si_pkg::OUT_BITS + 1;

  logic ch_v [QB+1];
  logic ch_r [QB+1];
  si_pkg::ctl_t ch_ctl [QB+1];
  logic [D-1:0] ch_d [QB+1];
  logic [D:0] ch_rx [QB+1];
  logic [D:0] ch_ry [QB+1];
  logic [QB-1:0] ch_lx [QB+1];
  logic [QB-1:0] ch_ly [QB+1];
  logic [QB-1:0] ch_qx [QB+1];
  logic [QB-1:0] ch_qy [QB+1];

  logic out_en;
  logic [XW-1:0] ex, ey;

  si_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .seg_in,
    .dn_valid(ch_v[0]), .dn_ready(ch_r[0]), .dn_ctl(ch_ctl[0]), .dn_d(ch_d[0]),
    .dn_rem_x(ch_rx[0]), .dn_rem_y(ch_ry[0]), .dn_l_x(ch_lx[0]), .dn_l_y(ch_ly[0])
  );

  assign ch_qx[0] = '0;
  assign ch_qy[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    si_div_cell #(.D(D), .QB(QB)) u_cell (
      .clk, .rst,
      .up_valid(ch_v[i]), .up_ready(ch_r[i]), .up_ctl(ch_ctl[i]), .up_d(ch_d[i]),
      .up_rem_x(ch_rx[i]), .up_rem_y(ch_ry[i]), .up_l_x(ch_lx[i]), .up_l_y(ch_ly[i]),
      .up_q_x(ch_qx[i]), .up_q_y(ch_qy[i]),
      .dn_valid(ch_v[i+1]), .dn_ready(ch_r[i+1]), .dn_ctl(ch_ctl[i+1]), .dn_d(ch_d[i+1]),
      .dn_rem_x(ch_rx[i+1]), .dn_rem_y(ch_ry[i+1]), .dn_l_x(ch_lx[i+1]),
      .dn_l_y(ch_ly[i+1]), .dn_q_x(ch_qx[i+1]), .dn_q_y(ch_qy[i+1])
    );
  end

  assign out_en   = !seg_out.valid || seg_out.ready;
  assign ch_r[QB] = out_en;

  always_comb begin
    ex = ch_ctl[QB].neg_x ? -XW'(ch_qx[QB]) : XW'(ch_qx[QB]);
    ey = ch_ctl[QB].neg_y ? -XW'(ch_qy[QB]) : XW'(ch_qy[QB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_out.valid <= 1'b0;
    end else if (out_en) begin
      seg_out.valid <= ch_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      seg_out.status <= ch_ctl[QB].status;
      if (ch_ctl[QB].status == si_pkg::ST_HIT) begin
        seg_out.cross_x <= ex[si_pkg::OUT_BITS-1:0];
        seg_out.cross_y <= ey[si_pkg::OUT_BITS-1:0];
      end else begin
        seg_out.cross_x <= '0;
        seg_out.cross_y <= '0;
      end
    end
  end

  // the dangling chain bits below are consumed
  logic unused_tail;
  assign unused_tail = ^{ch_d[QB], ch_rx[QB], ch_ry[QB], ch_lx[QB], ch_ly[QB]};

endmodule

// ===== hw/rtl/si_checker.sv =====
module si_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [31:0] cross_x,
  input logic [31:0] cross_y
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(cross_x) && $stable(cross_y))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == si_pkg::ST_HIT || status == si_pkg::ST_PARALLEL ||
                  status == si_pkg::ST_OUTSIDE)
    else $error("bad status code");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != si_pkg::ST_HIT |-> cross_x == '0 && cross_y == '0)
    else $error("crossing point given without a hit");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind segment_intersection_top si_checker u_si_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(seg_out.valid),
  .out_ready(seg_out.ready),
  .status(seg_out.status),
  .cross_x(seg_out.cross_x),
  .cross_y(seg_out.cross_y)
);

// ===== verif/tb_segment_intersection_top.sv =====
module tb_segment_intersection_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int LATENCY   = 6 + COORD_W + FRAC_W + 1;
  localparam int WDOG_MAX  = 5000;
  localparam int N_SMALL   = 500;
  localparam int N_FULL    = 350;
  localparam int N_AIMED   = 350;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t seg_pair_t [8];

  typedef struct {
    si_pkg::status_t status;
    logic [31:0]     cross_x;
    logic [31:0]     cross_y;
  } crossing_t;

  logic clk;
  logic rst;

  si_in_if #(.COORD_BITS(COORD_W)) seg_in_if ();
  si_out_if seg_out_if ();

  segment_intersection_top #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .seg_in (seg_in_if),
    .seg_out(seg_out_if)
  );

  crossing_t crossing_q[$];
  int        n_errors;
  int        idle_cycles;
  int        stall_pct;
  int        stall_hold;
  bit        no_gaps;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit in_box(longint q, int rs, longint lo, longint hi);
    longint ml;
    longint mh;
    bit     below;
    bit     above;
    ml    = lo * (longint'(1) << FRAC_W);
    mh    = hi * (longint'(1) << FRAC_W);
    below = (rs < 0) ? (q <= ml) : (q < ml);
    above = (rs > 0) ? (q >= mh) : (q > mh);
    return !below && !above;
  endfunction

  function automatic longint fix_div(logic signed [127:0] num, longint det, output int rs);
    logic [127:0] m;
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] d;
    bit           neg;
    neg = num[127];
    num = num <<< FRAC_W;
    m   = neg ? -num : num;
    d   = 128'(det);
    q   = m / d;
    r   = m % d;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    rs = (r == 0) ? 0 : (neg ? -1 : 1);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint min2(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint max2(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t c);
    longint             x1, y1, x2, y2, x3, y3, x4, y4;
    longint             a1, b1, c1, a2, b2, c2, det;
    logic signed [127:0] nx, ny;
    longint             qx, qy;
    int                 rx, ry;
    crossing_t          res;
    x1 = longint'(c[0]); y1 = longint'(c[1]); x2 = longint'(c[2]); y2 = longint'(c[3]);
    x3 = longint'(c[4]); y3 = longint'(c[5]); x4 = longint'(c[6]); y4 = longint'(c[7]);
    a1 = y2 - y1; b1 = x1 - x2; c1 = a1 * x1 + b1 * y1;
    a2 = y4 - y3; b2 = x3 - x4; c2 = a2 * x3 + b2 * y3;
    det = a1 * b2 - a2 * b1;
    res.status  = si_pkg::ST_PARALLEL;
    res.cross_x = '0;
    res.cross_y = '0;
    if (det == 0) return res;
    nx = 128'(b2) * 128'(c1) - 128'(b1) * 128'(c2);
    ny = 128'(a1) * 128'(c2) - 128'(a2) * 128'(c1);
    if (det < 0) begin
      nx  = -nx;
      ny  = -ny;
      det = -det;
    end
    qx = fix_div(nx, det, rx);
    qy = fix_div(ny, det, ry);
    if (!in_box(qx, rx, max2(min2(x1, x2), min2(x3, x4)), min2(max2(x1, x2), max2(x3, x4))) ||
        !in_box(qy, ry, max2(min2(y1, y2), min2(y3, y4)), min2(max2(y1, y2), max2(y3, y4)))) begin
      res.status = si_pkg::ST_OUTSIDE;
      return res;
    end
    res.status  = si_pkg::ST_HIT;
    res.cross_x = qx[31:0];
    res.cross_y = qy[31:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_pair(seg_pair_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      seg_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_in_if.valid          <= 1'b1;
    seg_in_if.first_start_x  <= c[0];
    seg_in_if.first_start_y  <= c[1];
    seg_in_if.first_end_x    <= c[2];
    seg_in_if.first_end_y    <= c[3];
    seg_in_if.second_start_x <= c[4];
    seg_in_if.second_start_y <= c[5];
    seg_in_if.second_end_x   <= c[6];
    seg_in_if.second_end_y   <= c[7];
    forever begin
      @(negedge clk);
      if (seg_in_if.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    crossing_q.push_back(predict_crossing(c));
  endtask

  task automatic send_coords(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pair_t p;
    p[0] = coord_t'(a); p[1] = coord_t'(b); p[2] = coord_t'(c); p[3] = coord_t'(d);
    p[4] = coord_t'(e); p[5] = coord_t'(f); p[6] = coord_t'(g); p[7] = coord_t'(h);
    send_pair(p);
  endtask

  task automatic wait_drained();
    while (crossing_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    no_gaps   = 1'b1;
    stall_pct = 0;
    send_coords(0, 0, 10, 10, 0, 10, 10, 0);
    send_coords(0, 0, 10, 10, 0, 1, 10, 11);
    send_coords(0, 0, 10, 10, 0, 0, 10, 10);
    send_coords(3, 3, 3, 3, 0, 0, 10, 10);
    send_coords(5, 5, 5, 5, 5, 5, 5, 5);
    send_coords(0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(0, 0, 1, 1, 10, 0, 10, 5);
    send_coords(0, 0, 4, 4, 4, 4, 8, 0);
    send_coords(0, 0, 4, 4, 5, 5, 8, 2);
    send_coords(0, 0, 3, 1, 0, 1, 1, 0);
    send_coords(0, 0, -3, -1, 0, -1, -1, 0);
    send_coords(0, 0, 2, 1, 1, 1, 3, 0);
    send_coords(0, 0, 3, 1, 2, 0, 2, 1);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_coords(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    send_coords(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
    send_coords(-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32768);
    send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
    send_coords(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    send_coords(-32768, 32767, 32767, -32768, -32768, -32768, 32766, 32767);
    send_coords(0, 0, 1, 32767, 1, 0, 0, 32767);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_full();
    seg_pair_t p;
    stall_pct = 20;
    repeat (N_FULL) begin
      foreach (p[i]) p[i] = coord_t'($urandom());
      send_pair(p);
    end
  endtask

  task automatic test_random_small();
    seg_pair_t p;
    int        base_x, base_y, span;
    stall_pct = 40;
    repeat (N_SMALL) begin
      span   = $urandom_range(1, 20);
      base_x = $urandom_range(0, 65535 - 2 * span) - 32768 + span;
      base_y = $urandom_range(0, 65535 - 2 * span) - 32768 + span;
      for (int i = 0; i < 8; i += 2) begin
        p[i]   = coord_t'(base_x + $urandom_range(0, 2 * span) - span);
        p[i+1] = coord_t'(base_y + $urandom_range(0, 2 * span) - span);
      end
      if ($urandom_range(0, 9) == 0) begin
        p[2] = p[0];
        p[3] = p[1];
      end
      send_pair(p);
    end
  endtask

  // segments built along lines through a common point, some stopping short of it
  task automatic test_random_aimed();
    seg_pair_t p;
    int        px, py, dx, dy, k1, k2, lim;
    stall_pct = 10;
    repeat (N_AIMED) begin
      lim = ($urandom_range(0, 3) == 0) ? 30000 : 200;
      px  = $urandom_range(0, 2 * lim) - lim;
      py  = $urandom_range(0, 2 * lim) - lim;
      for (int s = 0; s < 2; s++) begin
        dx = $urandom_range(0, 40) - 20;
        dy = $urandom_range(0, 40) - 20;
        k1 = $urandom_range(0, 60);
        k2 = $urandom_range(0, 60) - 5;
        p[4*s]   = coord_t'(px - k1 * dx);
        p[4*s+1] = coord_t'(py - k1 * dy);
        p[4*s+2] = coord_t'(px + k2 * dx);
        p[4*s+3] = coord_t'(py + k2 * dy);
      end
      send_pair(p);
    end
  endtask

  task automatic test_drain_pause();
    seg_pair_t p;
    stall_pct = 30;
    repeat (3) begin
      repeat (15) begin
        foreach (p[i]) p[i] = coord_t'($urandom_range(0, 40) - 20);
        send_pair(p);
      end
      seg_in_if.valid <= 1'b0;
      wait_drained();
      @(posedge clk);
    end
    no_gaps   = 1'b1;
    stall_pct = 0;
    repeat (30) begin
      foreach (p[i]) p[i] = coord_t'($urandom_range(0, 40) - 20);
      send_pair(p);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      seg_out_if.ready <= 1'b0;
      stall_hold       <= stall_hold - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < 2) begin
      seg_out_if.ready <= 1'b0;
      stall_hold       <= $urandom_range(10, 50);
    end else begin
      seg_out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // outputs sampled away from the active edge
  always @(negedge clk) begin
    crossing_t exp_c;
    if (!rst) begin
      if ((seg_in_if.valid && seg_in_if.ready) || (seg_out_if.valid && seg_out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
      if (seg_out_if.valid && seg_out_if.ready) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected transaction status %0d x %h y %h", $time,
                   seg_out_if.status, seg_out_if.cross_x, seg_out_if.cross_y);
          n_errors++;
        end else begin
          exp_c = crossing_q.pop_front();
          if (seg_out_if.status !== exp_c.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_c.status,
                     seg_out_if.status);
            n_errors++;
          end
          if (seg_out_if.cross_x !== exp_c.cross_x) begin
            $display("%0t: cross_x expected %h actual %h", $time, exp_c.cross_x,
                     seg_out_if.cross_x);
            n_errors++;
          end
          if (seg_out_if.cross_y !== exp_c.cross_y) begin
            $display("%0t: cross_y expected %h actual %h", $time, exp_c.cross_y,
                     seg_out_if.cross_y);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    n_errors                 = 0;
    idle_cycles              = 0;
    stall_pct                = 0;
    stall_hold               = 0;
    no_gaps                  = 1'b0;
    rst                      = 1'b1;
    seg_out_if.ready         = 1'b0;
    seg_in_if.valid          = 1'b0;
    seg_in_if.first_start_x  = '0;
    seg_in_if.first_start_y  = '0;
    seg_in_if.first_end_x    = '0;
    seg_in_if.first_end_y    = '0;
    seg_in_if.second_start_x = '0;
    seg_in_if.second_start_y = '0;
    seg_in_if.second_end_x   = '0;
    seg_in_if.second_end_y   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_small();
    test_random_full();
    test_random_aimed();
    test_drain_pause();
    seg_in_if.valid <= 1'b0;
    stall_pct = 20;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && crossing_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
